>>> design/pst_pkg.sv
// pst_pkg: shared types and codes for the processor-sharing task table.
// No dependencies.
`default_nettype none
package pst_pkg;

  localparam logic [2:0] KIND_DONE   = 3'd0;
  localparam logic [2:0] KIND_SCHED  = 3'd1;
  localparam logic [2:0] KIND_EMPTY  = 3'd2;
  localparam logic [2:0] KIND_NOHEAD = 3'd3;
  localparam logic [2:0] KIND_FULL   = 3'd4;

  localparam logic [1:0] CFG_BANDWIDTH = 2'd0;
  localparam logic [1:0] CFG_SLOTS     = 2'd1;

  typedef struct packed {
    logic [31:0] work;
    logic [15:0] tag;
  } entry_t;

  typedef struct packed {
    logic        start;
    logic [63:0] num;
    logic [31:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quot;
  } div_rsp_t;

endpackage
`default_nettype wire

>>> design/pst_ram.sv
// pst_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module pst_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

>>> design/pst_div.sv
// pst_div: 64 by 32 bit restoring divider, one quotient bit per cycle.
// Depends on pst_pkg.
`default_nettype none
module pst_div (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire pst_pkg::div_req_t req,
  output pst_pkg::div_rsp_t      rsp
);
  import pst_pkg::*;

  logic [63:0] quot;
  logic [32:0] rem;
  logic [31:0] den;
  logic [6:0]  cnt;
  logic        busy;
  logic        done;
  logic [32:0] trial;

  assign trial = {rem[31:0], quot[63]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        quot <= req.num;
        den  <= req.den;
        rem  <= '0;
        cnt  <= 7'd64;
        busy <= 1'b1;
      end else if (busy) begin
        if (trial >= {1'b0, den}) begin
          rem  <= trial - {1'b0, den};
          quot <= {quot[62:0], 1'b1};
        end else begin
          rem  <= trial;
          quot <= {quot[62:0], 1'b0};
        end
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quot = quot;
endmodule
`default_nettype wire

>>> design/processor_sharing_task_table.sv
// Processor-sharing task table, top level. Depends on pst_pkg, pst_ram, pst_div.
// One item at a time; an item takes the decay/merge pass over the entry RAM, the
// share divide when count > slots, a pop per finished task and the delay divide,
// plus handshakes.
// Synchronous active-high reset empties the table, clears time, sets registers to 1.
`default_nettype none
module processor_sharing_task_table #(
  parameter int TABLE_DEPTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        cmd,
  input  wire logic [31:0] now,
  input  wire logic [31:0] task_units,
  input  wire logic [15:0] task_tag,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       kind,
  output logic [15:0]      finished_tag,
  output logic [31:0]      next_delay,
  output logic             last_result,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);
  import pst_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MUL   = 4'd1;
  localparam logic [3:0] S_MUL2  = 4'd2;
  localparam logic [3:0] S_LWAIT = 4'd3;
  localparam logic [3:0] S_RD    = 4'd4;
  localparam logic [3:0] S_WR    = 4'd5;
  localparam logic [3:0] S_INS   = 4'd6;
  localparam logic [3:0] S_SCHK  = 4'd7;
  localparam logic [3:0] S_SRD   = 4'd8;
  localparam logic [3:0] S_SEVAL = 4'd9;
  localparam logic [3:0] S_DLY   = 4'd10;
  localparam logic [3:0] S_DWAIT = 4'd11;
  localparam logic [3:0] S_EMIT  = 4'd12;

  logic [3:0]    state;
  logic [3:0]    ret;
  logic [15:0]   bandwidth;
  logic [6:0]    slots;
  logic [CW-1:0] count;
  logic [AW-1:0] head;
  logic [31:0]   last_time;
  logic [CW-1:0] idx;
  logic          op;
  logic [31:0]   units;
  logic [15:0]   tag;
  logic [31:0]   elapsed;
  logic [63:0]   loss;
  logic          placed;
  logic          force_pop;
  entry_t        pend;
  logic [63:0]   num;
  logic [31:0]   den;

  logic [15:0]   ebw;
  logic [6:0]    eslots;
  logic          shared;
  logic [47:0]   bwt;
  logic [31:0]   dec;
  entry_t        rd_entry;
  entry_t        new_entry;
  entry_t        wdata;
  logic          we;
  logic          re;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;
  logic [47:0]   rdata;
  div_req_t      dreq;
  div_rsp_t      drsp;

  function automatic logic [AW-1:0] phys(input logic [AW-1:0] h, input logic [CW-1:0] i);
    logic [CW:0] s;
    s = (CW+1)'(h) + (CW+1)'(i);
    if (s >= (CW+1)'(TABLE_DEPTH)) begin
      s = s - (CW+1)'(TABLE_DEPTH);
    end
    return AW'(s);
  endfunction

  assign ebw       = (bandwidth == 16'd0) ? 16'd1 : bandwidth;
  assign eslots    = (slots == 7'd0) ? 7'd1 : slots;
  assign shared    = 32'(count) > 32'(eslots);
  assign bwt       = ebw * elapsed;
  assign rd_entry  = entry_t'(rdata);
  assign dec       = (64'(rd_entry.work) > loss) ? (rd_entry.work - loss[31:0]) : 32'd0;
  assign new_entry = '{work: units, tag: tag};
  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);

  always_comb begin
    we    = 1'b0;
    waddr = phys(head, idx);
    wdata = '{work: dec, tag: rd_entry.tag};
    re    = 1'b0;
    raddr = phys(head, idx);
    case (state)
      S_RD: begin
        re = (idx != count);
      end
      S_WR: begin
        we = 1'b1;
        if (op == 1'b0 && !placed && dec > units) begin
          wdata = new_entry;
        end else if (op == 1'b0 && placed) begin
          wdata = pend;
        end
      end
      S_INS: begin
        we    = 1'b1;
        waddr = phys(head, count);
        wdata = placed ? pend : new_entry;
      end
      S_SRD: begin
        re    = 1'b1;
        raddr = head;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    dreq.start = 1'b0;
    dreq.num   = num;
    dreq.den   = den;
    case (state)
      S_MUL2: begin
        dreq.start = 1'b1;
        dreq.num   = loss * 64'(eslots);
        dreq.den   = 32'(count);
      end
      S_DLY: begin
        dreq.start = 1'b1;
        dreq.num   = num + 64'(den) - 64'd1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ret       <= S_IDLE;
      bandwidth <= 16'd1;
      slots     <= 7'd1;
      count     <= '0;
      head      <= '0;
      last_time <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_BANDWIDTH) begin
          bandwidth <= cfg_data[15:0];
        end else if (cfg_index == CFG_SLOTS) begin
          slots <= cfg_data[6:0];
        end
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op      <= cmd;
            units   <= task_units;
            tag     <= task_tag;
            elapsed <= now - last_time;
            if (cmd == 1'b1 && count == '0) begin
              kind         <= KIND_NOHEAD;
              finished_tag <= '0;
              next_delay   <= '0;
              last_result  <= 1'b1;
              out_valid    <= 1'b1;
              ret          <= S_IDLE;
              state        <= S_EMIT;
            end else if (cmd == 1'b0 && count == CW'(TABLE_DEPTH)) begin
              kind         <= KIND_FULL;
              finished_tag <= '0;
              next_delay   <= '0;
              last_result  <= 1'b1;
              out_valid    <= 1'b1;
              ret          <= S_IDLE;
              state        <= S_EMIT;
            end else begin
              last_time <= now;
              state     <= S_MUL;
            end
          end
        end
        S_MUL: begin
          loss   <= {8'd0, bwt, 8'd0};
          idx    <= '0;
          placed <= 1'b0;
          state  <= shared ? S_MUL2 : S_RD;
        end
        S_MUL2: begin
          state <= S_LWAIT;
        end
        S_LWAIT: begin
          if (drsp.done) begin
            loss  <= drsp.quot;
            state <= S_RD;
          end
        end
        S_RD: begin
          if (idx == count) begin
            force_pop <= op;
            state     <= (op == 1'b0) ? S_INS : S_SCHK;
          end else begin
            state <= S_WR;
          end
        end
        S_WR: begin
          if (op == 1'b0 && (placed || dec > units)) begin
            placed <= 1'b1;
            pend   <= '{work: dec, tag: rd_entry.tag};
          end
          idx   <= idx + CW'(1);
          state <= S_RD;
        end
        S_INS: begin
          count <= count + CW'(1);
          state <= S_SCHK;
        end
        S_SCHK: begin
          if (count == '0) begin
            kind         <= KIND_EMPTY;
            finished_tag <= '0;
            next_delay   <= '0;
            last_result  <= 1'b1;
            out_valid    <= 1'b1;
            ret          <= S_IDLE;
            state        <= S_EMIT;
          end else begin
            state <= S_SRD;
          end
        end
        S_SRD: begin
          state <= S_SEVAL;
        end
        S_SEVAL: begin
          if (force_pop || rd_entry.work == 32'd0) begin
            kind         <= KIND_DONE;
            finished_tag <= rd_entry.tag;
            next_delay   <= '0;
            last_result  <= 1'b0;
            out_valid    <= 1'b1;
            head         <= phys(head, CW'(1));
            count        <= count - CW'(1);
            force_pop    <= 1'b0;
            ret          <= S_SCHK;
            state        <= S_EMIT;
          end else begin
            num   <= 64'(rd_entry.work) * 64'(shared ? count : CW'(1));
            den   <= {1'b0, 23'(ebw) * 23'(shared ? eslots : 7'd1), 8'd0};
            state <= S_DLY;
          end
        end
        S_DLY: begin
          state <= S_DWAIT;
        end
        S_DWAIT: begin
          if (drsp.done) begin
            kind         <= KIND_SCHED;
            finished_tag <= '0;
            next_delay   <= (drsp.quot[63:32] != 32'd0) ? 32'hFFFF_FFFF : drsp.quot[31:0];
            last_result  <= 1'b1;
            out_valid    <= 1'b1;
            ret          <= S_IDLE;
            state        <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            state     <= ret;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  pst_ram #(.WIDTH(48), .DEPTH(TABLE_DEPTH)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  pst_div u_div (
    .clk (clk),
    .rst (rst),
    .req (dreq),
    .rsp (drsp)
  );
endmodule
`default_nettype wire

>>> design/pst_checker.sv
// pst_checker: port-level assertions for the task table, bound to the top level.
// Depends on pst_pkg and processor_sharing_task_table.
`default_nettype none
module pst_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [2:0] kind,
  input wire logic       last_result
);
  import pst_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid) else $error("result dropped while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("request taken while result pending");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall) else $error("not busy after request");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && last_result |=> !out_valid) else $error("result after last");

  a_kind_last: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (kind == KIND_DONE) == !last_result) else $error("bad last flag");
endmodule

bind processor_sharing_task_table pst_checker u_pst_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .kind        (kind),
  .last_result (last_result)
);
`default_nettype wire
